[hdl/mqe_pkg.sv]
// Shared types, constants and character helpers for the Q encoded-word encoder.
`timescale 1ns / 1ps
package mqe_pkg;

	localparam int WORD_LIMIT = 75;
	localparam int PREFIX_LEN = 10;
	localparam int SUFFIX_LEN = 2;
	localparam logic [5:0] MAX_LEN_RST = 6'(WORD_LIMIT - PREFIX_LEN - SUFFIX_LEN);
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [127:0] HEX_DIGITS = "0123456789ABCDEF";

	typedef enum logic [2:0] {
		PH_START,
		PH_CLOSE,
		PH_SPACE,
		PH_PREFIX,
		PH_BYTE,
		PH_TAIL
	} phase_t;

	// One finished character and the framing that comes with it.
	typedef struct packed {
		logic            close_first;
		logic            open_word;
		logic            lead_space;
		logic            eot;
		logic [1:0]      last_idx;
		logic [3:0][7:0] bytes;
	} job_t;

	function automatic logic [1:0] lead_len_m1(input logic [7:0] b);
		logic [1:0] r;
		r = 2'd0;
		if (b[7] == 1'b0)
			r = 2'd0;
		else if ((b & 8'hE0) == 8'hC0)
			r = 2'd1;
		else if ((b & 8'hF0) == 8'hE0)
			r = 2'd2;
		else if ((b & 8'hF8) == 8'hF0)
			r = 2'd3;
		return r;
	endfunction

	function automatic logic q_plain(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
		       (b >= 8'h30 && b <= 8'h39) || b == 8'h21 || b == 8'h2A ||
		       b == 8'h2B || b == 8'h2D || b == 8'h2F;
	endfunction

	function automatic logic q_single(input logic [7:0] b);
		return (b == CH_SPACE) || q_plain(b);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return HEX_DIGITS[(7'd15 - {3'd0, nib}) * 8 +: 8];
	endfunction

	function automatic logic [7:0] prefix_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = "=";
			4'd1: c = "?";
			4'd2: c = "U";
			4'd3: c = "T";
			4'd4: c = "F";
			4'd5: c = "-";
			4'd6: c = "8";
			4'd7: c = "?";
			4'd8: c = "Q";
			4'd9: c = "?";
			default: c = "?";
		endcase
		return c;
	endfunction

endpackage

[hdl/mqe_front.sv]
// Front end: groups UTF-8 bytes into characters and decides word framing.
`timescale 1ns / 1ps
module mqe_front
	import mqe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] data_byte,
	input  logic       end_of_text,
	input  logic [5:0] max_len,
	input  logic       fifo_full,
	output logic       in_stall,
	output logic       push,
	output job_t       job
);

	logic [1:0] need_q;
	logic [1:0] pcount_q;
	logic [3:0] penc_q;
	logic [5:0] chunk_q;
	logic       any_word_q;
	logic [7:0] pend_q [3];

	logic       accept;
	logic       need_is0;
	logic [1:0] need_d0;
	logic [1:0] cnt0;
	logic [3:0] penc0;
	logic [3:0] enc;
	logic       finish;
	logic [6:0] sum7;
	logic       close_w;
	logic       open_w;
	logic [5:0] new_chunk;

	assign in_stall = fifo_full;
	assign accept   = in_valid && !fifo_full;

	always_comb begin
		need_is0  = (need_q == 2'd0);
		need_d0   = need_is0 ? lead_len_m1(data_byte) : need_q - 2'd1;
		cnt0      = need_is0 ? 2'd0 : pcount_q;
		penc0     = need_is0 ? 4'd0 : penc_q;
		enc       = penc0 + (q_single(data_byte) ? 4'd1 : 4'd3);
		finish    = (need_d0 == 2'd0) || end_of_text;
		sum7      = {1'b0, chunk_q} + {3'b000, enc};
		close_w   = (chunk_q != 6'd0) && (sum7 > {1'b0, max_len});
		open_w    = close_w || (chunk_q == 6'd0);
		new_chunk = (close_w ? 6'd0 : chunk_q) + {2'b00, enc};
	end

	always_comb begin
		job.close_first = close_w;
		job.open_word   = open_w;
		job.lead_space  = open_w && any_word_q;
		job.eot         = end_of_text;
		job.last_idx    = cnt0;
		for (int i = 0; i < 3; i++) begin
			job.bytes[i] = (cnt0 == 2'(i)) ? data_byte : pend_q[i];
		end
		job.bytes[3] = data_byte;
	end

	assign push = accept && finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q     <= 2'd0;
			pcount_q   <= 2'd0;
			penc_q     <= 4'd0;
			chunk_q    <= 6'd0;
			any_word_q <= 1'b0;
		end else if (accept) begin
			if (!finish) begin
				need_q   <= need_d0;
				pcount_q <= cnt0 + 2'd1;
				penc_q   <= enc;
			end else begin
				need_q     <= 2'd0;
				pcount_q   <= 2'd0;
				penc_q     <= 4'd0;
				chunk_q    <= end_of_text ? 6'd0 : new_chunk;
				any_word_q <= !end_of_text;
			end
		end
	end

	// Hold the bytes of an unfinished character.
	always_ff @(posedge clk) begin
		if (accept && !finish) begin
			for (int i = 0; i < 3; i++) begin
				if (cnt0 == 2'(i))
					pend_q[i] <= data_byte;
			end
		end
	end

endmodule

[hdl/mqe_job_fifo.sv]
// Short job queue between the front end and the character sequencer.
`timescale 1ns / 1ps
module mqe_job_fifo
	import mqe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic empty,
	output job_t head
);

	job_t                mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QPTR_W:0]     count_q;

	assign full  = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_job;
	end

endmodule

[hdl/mqe_back.sv]
// Back end: walks one job per character and emits encoded text beats.
`timescale 1ns / 1ps
module mqe_back
	import mqe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	input  job_t       head,
	output logic       pop,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [7:0] out_char,
	output logic       run_last,
	output logic       text_done
);

	phase_t     phase_q;
	logic [3:0] idx_q;
	logic [1:0] bi_q;
	logic [1:0] di_q;
	logic       out_valid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       done_q;

	phase_t     cur_ph;
	phase_t     after_close;
	phase_t     ph_d;
	logic [3:0] idx_d;
	logic [1:0] bi_d;
	logic [1:0] di_d;
	logic       job_end;
	logic       take;
	logic [7:0] cur_byte;
	logic       char_done;
	logic       byte_last;
	logic [7:0] char_w;
	logic       last_w;

	assign take     = job_valid && (!out_valid_q || !out_stall);
	assign pop      = take && job_end;
	assign cur_byte = head.bytes[bi_q];
	assign char_done = q_single(cur_byte) || (di_q == 2'd2);
	assign byte_last = (bi_q == head.last_idx);

	always_comb begin
		after_close = head.lead_space ? PH_SPACE : (head.open_word ? PH_PREFIX : PH_BYTE);
		if (phase_q == PH_START)
			cur_ph = head.close_first ? PH_CLOSE : after_close;
		else
			cur_ph = phase_q;
	end

	// Next state
	always_comb begin
		ph_d    = cur_ph;
		idx_d   = idx_q;
		bi_d    = bi_q;
		di_d    = di_q;
		job_end = 1'b0;
		case (cur_ph)
			PH_CLOSE: begin
				if (idx_q == 4'd1) begin
					ph_d  = after_close;
					idx_d = 4'd0;
				end else begin
					idx_d = idx_q + 4'd1;
				end
			end
			PH_SPACE: begin
				ph_d = PH_PREFIX;
			end
			PH_PREFIX: begin
				if (idx_q == 4'(PREFIX_LEN - 1)) begin
					ph_d  = PH_BYTE;
					idx_d = 4'd0;
				end else begin
					idx_d = idx_q + 4'd1;
				end
			end
			PH_BYTE: begin
				if (char_done) begin
					di_d = 2'd0;
					if (byte_last) begin
						bi_d = 2'd0;
						if (head.eot)
							ph_d = PH_TAIL;
						else
							job_end = 1'b1;
					end else begin
						bi_d = bi_q + 2'd1;
					end
				end else begin
					di_d = di_q + 2'd1;
				end
			end
			PH_TAIL: begin
				if (idx_q == 4'd1)
					job_end = 1'b1;
				else
					idx_d = idx_q + 4'd1;
			end
			default: begin
				ph_d = cur_ph;
			end
		endcase
		if (job_end) begin
			ph_d  = PH_START;
			idx_d = 4'd0;
			bi_d  = 2'd0;
			di_d  = 2'd0;
		end
	end

	// Outputs
	always_comb begin
		char_w = CH_QMARK;
		last_w = 1'b0;
		case (cur_ph)
			PH_CLOSE: char_w = (idx_q == 4'd0) ? CH_QMARK : CH_EQUALS;
			PH_SPACE: char_w = CH_SPACE;
			PH_PREFIX: char_w = prefix_char(idx_q);
			PH_BYTE: begin
				if (cur_byte == CH_SPACE)
					char_w = CH_UNDERSCORE;
				else if (q_plain(cur_byte))
					char_w = cur_byte;
				else if (di_q == 2'd0)
					char_w = CH_EQUALS;
				else if (di_q == 2'd1)
					char_w = hex_char(cur_byte[7:4]);
				else
					char_w = hex_char(cur_byte[3:0]);
				last_w = char_done && byte_last && !head.eot;
			end
			PH_TAIL: begin
				char_w = (idx_q == 4'd0) ? CH_QMARK : CH_EQUALS;
				last_w = (idx_q == 4'd1);
			end
			default: char_w = CH_QMARK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			idx_q       <= 4'd0;
			bi_q        <= 2'd0;
			di_q        <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q     <= ph_d;
				idx_q       <= idx_d;
				bi_q        <= bi_d;
				di_q        <= di_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_q <= char_w;
			last_q <= last_w;
			done_q <= last_w && head.eot;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = char_q;
	assign run_last  = last_q;
	assign text_done = done_q;

endmodule

[hdl/mime_q_encoded_word_encoder.sv]
// Top level of the streaming Q encoded-word (UTF-8) header encoder.
`timescale 1ns / 1ps
// Takes UTF-8 text one byte per input beat and produces the encoded header
// text one ASCII character per output beat, packed into words of the form
// =?UTF-8?Q?...?= with at most max_text_len encoded characters per word unless
// one character alone is longer; a new word follows after one space and a
// character is never split. The front end takes one byte per clock while its
// two-entry job queue has room; a byte that finishes a character becomes one
// job. The back end emits exactly one character per clock while a job is
// queued and the output is not stalled. A job yields 1 character for a plain
// byte, 3 for an escaped one, 25 for four escaped bytes that close a word and
// open a new one, and up to 27 when the text also ends on that character.
// An unfinished multi-byte character costs nothing until its last byte.
// Sustained throughput is therefore set by the output channel at one
// character per clock. The configuration write port is always ready; write
// it only while no text is in flight. run_last marks the final character
// caused by an input byte, text_done the closing '=' of the whole text.
module mime_q_encoded_word_encoder
	import mqe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [5:0] max_text_len,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_text,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       run_last,
	output logic       text_done
);

	logic [5:0] max_len_q;
	logic       fifo_full;
	logic       fifo_empty;
	logic       front_push;
	logic       back_pop;
	job_t       front_job;
	job_t       head_job;

	// Take a register write on every beat; the port never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_len_q <= MAX_LEN_RST;
		else if (cfg_valid && cfg_ready)
			max_len_q <= max_text_len;
	end

	// Group bytes into characters, track word fill and decide framing.
	mqe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.data_byte  (data_byte),
		.end_of_text(end_of_text),
		.max_len    (max_len_q),
		.fifo_full  (fifo_full),
		.in_stall   (in_stall),
		.push       (front_push),
		.job        (front_job)
	);

	// Decouple the two sides so a stalled output does not block byte intake while the queue has room.
	mqe_job_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (front_push),
		.push_job(front_job),
		.pop     (back_pop),
		.full    (fifo_full),
		.empty   (fifo_empty),
		.head    (head_job)
	);

	// Expand each job into close, space, prefix, encoded bytes and tail.
	mqe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(!fifo_empty),
		.head     (head_job),
		.pop      (back_pop),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_char (out_char),
		.run_last (run_last),
		.text_done(text_done)
	);

`ifndef SYNTH
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		front_push |-> !fifo_full)
		else $error("job pushed into a full queue");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && text_done) |-> run_last)
		else $error("text_done without run_last");

	a_done_char: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && text_done) |-> (out_char == CH_EQUALS))
		else $error("text_done not on the closing equals sign");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		back_pop |-> !fifo_empty)
		else $error("job popped from an empty queue");
`endif

endmodule
